// ----- hdl/ecpa_pkg.sv -----
`timescale 1ns / 1ps

package ecpa_pkg;

  // Configuration register indexes.
  typedef logic [0:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CURVE_A = 1'b0;
  localparam cfg_idx_t CFG_MODULUS = 1'b1;

  // Reset values of the configuration registers.
  localparam int unsigned CURVE_A_RESET = 1;
  localparam int unsigned MODULUS_RESET = 23;

endpackage

// ----- hdl/ecpa_mulmod.sv -----
`timescale 1ns / 1ps

module ecpa_mulmod #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] op_x,
  input  logic [W-1:0] op_y,
  input  logic [W-1:0] modulus,
  output logic         done,
  output logic [W-1:0] result
);
  import ecpa_pkg::*;

  localparam int CW = $clog2(W + 1);
  localparam logic [CW-1:0] CNT_INIT = CW'(W);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  logic [W-1:0]  x_r, y_r, acc_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;
  logic [W-1:0]  dbl, acc_nxt;

  function automatic logic [W-1:0] madd(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [W-1:0] m);
    logic [W:0] s;
    logic [W:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, m};
    madd = (s >= {1'b0, m}) ? d[W-1:0] : s[W-1:0];
  endfunction

  // Left-to-right double and add, one multiplier bit per cycle.
  always_comb begin
    dbl     = madd(acc_r, acc_r, modulus);
    acc_nxt = y_r[W-1] ? madd(dbl, x_r, modulus) : dbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && run_r && (cnt_r == CNT_ONE);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_INIT;
        acc_r <= '0;
        x_r   <= op_x;
        y_r   <= op_y;
      end else if (run_r) begin
        acc_r <= acc_nxt;
        y_r   <= {y_r[W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_ONE;
        if (cnt_r == CNT_ONE) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < modulus))
    else $error("product not reduced below the modulus");

endmodule

// ----- hdl/ec_point_add_prime_field.sv -----
`timescale 1ns / 1ps

// Every multiplication, reduction and Euclid division runs one bit per cycle.
// One word is in work at a time; a new word is taken while the last result waits.
// Synchronous active-low reset clears control state and sets a = 1, p = 23.
module ec_point_add_prime_field #(
  parameter int FIELD_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FIELD_BITS-1:0]    in_first_x,
  input  logic [FIELD_BITS-1:0]    in_first_y,
  input  logic [FIELD_BITS-1:0]    in_second_x,
  input  logic [FIELD_BITS-1:0]    in_second_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [FIELD_BITS-1:0]    out_sum_x,
  output logic [FIELD_BITS-1:0]    out_sum_y,
  output logic                     out_at_infinity,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  ecpa_pkg::cfg_idx_t       cfg_index,
  input  logic [FIELD_BITS-1:0]    cfg_data
);
  import ecpa_pkg::*;

  localparam int W  = FIELD_BITS;
  localparam int CW = $clog2(W + 1);
  localparam logic [CW-1:0] CNT_INIT = CW'(W);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [W-1:0]  ONE      = W'(1);
  localparam logic [W-1:0]  TWO      = W'(2);

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_CMP, S_SQ, S_NUM2, S_NUM3, S_INVCHK, S_DIVINIT, S_DIV,
    S_DIVUPD, S_LAM, S_LSQ, S_X3, S_YMUL, S_DONE
  } state_t;

  state_t state_r;

  logic [W-1:0]  coeff_a_r, modulus_r;
  logic [W-1:0]  x1_r, y1_r, x2_r, y2_r, a_r;
  logic [W-1:0]  num_r, den_r, tmp_r, lam_r, sx_r, sy_r;
  logic [W-1:0]  r0_r, r1_r, t0_r, t1_r, rem_r, qt_r, dsh_r;
  logic [CW-1:0] cnt_r;
  logic [2:0]    red_idx_r;
  logic          inf_r;

  logic          mul_start_r;
  logic [W-1:0]  mul_x_r, mul_y_r;
  logic          mul_done;
  logic [W-1:0]  mul_res;

  logic          out_valid_r, out_inf_r;
  logic [W-1:0]  out_x_r, out_y_r;

  logic [W:0]    rem_w;
  logic          div_ge;
  logic [W-1:0]  rem_nxt, qt_dbl, qt_nxt;

  function automatic logic [W-1:0] madd(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [W-1:0] m);
    logic [W:0] s;
    logic [W:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, m};
    madd = (s >= {1'b0, m}) ? d[W-1:0] : s[W-1:0];
  endfunction

  // Both operands are already below m, so a wrapped difference plus m lands in range.
  function automatic logic [W-1:0] msub(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [W-1:0] m);
    msub = (a >= b) ? (a - b) : (a - b + m);
  endfunction

  ecpa_mulmod #(.W(W)) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .op_x    (mul_x_r),
    .op_y    (mul_y_r),
    .modulus (modulus_r),
    .done    (mul_done),
    .result  (mul_res)
  );

  // One restoring division bit per cycle; the quotient bits also drive a Horner
  // accumulation of q * t1 mod p for the cofactor update.
  always_comb begin
    rem_w   = {rem_r, dsh_r[W-1]};
    div_ge  = (rem_w >= {1'b0, r1_r});
    rem_nxt = div_ge ? W'(rem_w - {1'b0, r1_r}) : rem_w[W-1:0];
    qt_dbl  = madd(qt_r, qt_r, modulus_r);
    qt_nxt  = div_ge ? madd(qt_dbl, t1_r, modulus_r) : qt_dbl;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_a_r <= W'(CURVE_A_RESET);
      modulus_r <= W'(MODULUS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CURVE_A: coeff_a_r <= cfg_data;
        CFG_MODULUS: modulus_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      red_idx_r   <= '0;
      cnt_r       <= '0;
      inf_r       <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          mul_start_r <= in_valid && (modulus_r >= TWO);
          if (in_valid) begin
            x1_r  <= in_first_x;
            y1_r  <= in_first_y;
            x2_r  <= in_second_x;
            y2_r  <= in_second_y;
            a_r   <= coeff_a_r;
            inf_r <= (modulus_r < TWO);
            if (modulus_r < TWO) begin
              state_r <= S_DONE;
            end else begin
              // Reduction is a multiplication by one.
              mul_x_r   <= ONE;
              mul_y_r   <= in_first_x;
              red_idx_r <= '0;
              state_r   <= S_RED;
            end
          end
        end
        S_RED: begin
          mul_start_r <= mul_done && (red_idx_r < 3'd4);
          if (mul_done) begin
            red_idx_r <= red_idx_r + 3'd1;
            mul_x_r   <= ONE;
            unique case (red_idx_r)
              3'd0: begin x1_r <= mul_res; mul_y_r <= y1_r; end
              3'd1: begin y1_r <= mul_res; mul_y_r <= x2_r; end
              3'd2: begin x2_r <= mul_res; mul_y_r <= y2_r; end
              3'd3: begin y2_r <= mul_res; mul_y_r <= a_r;  end
              default: begin
                a_r     <= mul_res;
                state_r <= S_CMP;
              end
            endcase
          end
        end
        S_CMP: begin
          mul_start_r <= (x1_r == x2_r && y1_r == y2_r);
          if (x1_r == x2_r && y1_r == y2_r) begin
            den_r   <= madd(y1_r, y1_r, modulus_r);
            mul_x_r <= x1_r;
            mul_y_r <= x1_r;
            state_r <= S_SQ;
          end else begin
            num_r   <= msub(y2_r, y1_r, modulus_r);
            den_r   <= msub(x2_r, x1_r, modulus_r);
            state_r <= S_INVCHK;
          end
        end
        S_SQ: begin
          mul_start_r <= 1'b0;
          if (mul_done) begin
            tmp_r   <= mul_res;
            num_r   <= madd(mul_res, mul_res, modulus_r);
            state_r <= S_NUM2;
          end
        end
        S_NUM2: begin
          mul_start_r <= 1'b0;
          num_r       <= madd(num_r, tmp_r, modulus_r);
          state_r     <= S_NUM3;
        end
        S_NUM3: begin
          mul_start_r <= 1'b0;
          num_r       <= madd(num_r, a_r, modulus_r);
          state_r     <= S_INVCHK;
        end
        S_INVCHK: begin
          mul_start_r <= 1'b0;
          if (den_r == '0) begin
            inf_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            r0_r    <= modulus_r;
            r1_r    <= den_r;
            t0_r    <= '0;
            t1_r    <= ONE;
            state_r <= S_DIVINIT;
          end
        end
        S_DIVINIT: begin
          mul_start_r <= (r1_r == '0) && (r0_r == ONE);
          if (r1_r == '0) begin
            if (r0_r == ONE) begin
              mul_x_r <= num_r;
              mul_y_r <= t0_r;
              state_r <= S_LAM;
            end else begin
              inf_r   <= 1'b1;
              state_r <= S_DONE;
            end
          end else begin
            dsh_r   <= r0_r;
            rem_r   <= '0;
            qt_r    <= '0;
            cnt_r   <= CNT_INIT;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          mul_start_r <= 1'b0;
          rem_r       <= rem_nxt;
          qt_r        <= qt_nxt;
          dsh_r       <= {dsh_r[W-2:0], 1'b0};
          cnt_r       <= cnt_r - CNT_ONE;
          if (cnt_r == CNT_ONE) begin
            state_r <= S_DIVUPD;
          end
        end
        S_DIVUPD: begin
          mul_start_r <= 1'b0;
          r0_r        <= r1_r;
          r1_r        <= rem_r;
          t0_r        <= t1_r;
          t1_r        <= msub(t0_r, qt_r, modulus_r);
          state_r     <= S_DIVINIT;
        end
        S_LAM: begin
          mul_start_r <= mul_done;
          if (mul_done) begin
            lam_r   <= mul_res;
            mul_x_r <= mul_res;
            mul_y_r <= mul_res;
            state_r <= S_LSQ;
          end
        end
        S_LSQ: begin
          mul_start_r <= 1'b0;
          if (mul_done) begin
            sx_r    <= msub(msub(mul_res, x1_r, modulus_r), x2_r, modulus_r);
            state_r <= S_X3;
          end
        end
        S_X3: begin
          mul_start_r <= 1'b1;
          mul_x_r     <= lam_r;
          mul_y_r     <= msub(x1_r, sx_r, modulus_r);
          state_r     <= S_YMUL;
        end
        S_YMUL: begin
          mul_start_r <= 1'b0;
          if (mul_done) begin
            sy_r    <= msub(mul_res, y1_r, modulus_r);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          mul_start_r <= 1'b0;
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_inf_r   <= inf_r;
            out_x_r     <= inf_r ? '0 : sx_r;
            out_y_r     <= inf_r ? '0 : sy_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          mul_start_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_sum_x       = out_x_r;
  assign out_sum_y       = out_y_r;
  assign out_at_infinity = out_inf_r;

  a_mul_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_RED || state_r == S_SQ || state_r == S_LAM ||
                  state_r == S_LSQ || state_r == S_YMUL))
    else $error("multiplier finished with no state waiting for it");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> (rem_r < r1_r))
    else $error("division remainder not below divisor");

  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inf_r) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("point at infinity with nonzero coordinates");

  a_sum_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_inf_r) |-> (out_x_r < modulus_r && out_y_r < modulus_r))
    else $error("sum coordinates not reduced");

endmodule

// ----- dv/ec_point_add_prime_field_test.sv -----
`timescale 1ns / 1ps

module ec_point_add_prime_field_test;
  import ecpa_pkg::*;

  localparam int FB = 16;
  localparam int LIMIT_CYCLES = 4000000;

  typedef logic [FB-1:0] fe_t;
  typedef struct packed {
    fe_t  sum_x;
    fe_t  sum_y;
    logic at_infinity;
  } point_sum_t;

  // Field arithmetic on 64-bit values; operands are always below the modulus.
  function automatic longint unsigned fadd(longint unsigned x, longint unsigned y,
                                           longint unsigned m);
    if (x >= m - y) return x - (m - y);
    return x + y;
  endfunction

  function automatic longint unsigned fsub(longint unsigned x, longint unsigned y,
                                           longint unsigned m);
    if (x >= y) return x - y;
    return x + (m - y);
  endfunction

  function automatic longint unsigned fmul(longint unsigned x, longint unsigned y,
                                           longint unsigned m);
    return (x * y) % m;
  endfunction

  class point_sum_board;
    fe_t coeff_a = fe_t'(CURVE_A_RESET);
    fe_t modulus = fe_t'(MODULUS_RESET);
    point_sum_t pending[$];
    int errors = 0;

    function void note_points(fe_t x1i, fe_t y1i, fe_t x2i, fe_t y2i);
      longint unsigned m, x1, y1, x2, y2, a, num, den, r0, r1, t0, t1, q, nr, nt;
      longint unsigned lam, x3, y3, sq;
      point_sum_t s;
      s = '{sum_x: '0, sum_y: '0, at_infinity: 1'b1};
      m = modulus;
      if (m >= 2) begin
        x1 = x1i % m;
        y1 = y1i % m;
        x2 = x2i % m;
        y2 = y2i % m;
        a = coeff_a % m;
        if (x1 == x2 && y1 == y2) begin
          sq = fmul(x1, x1, m);
          num = fadd(fadd(fadd(sq, sq, m), sq, m), a, m);
          den = fadd(y1, y1, m);
        end else begin
          num = fsub(y2, y1, m);
          den = fsub(x2, x1, m);
        end
        if (den != 0) begin
          r0 = m; r1 = den; t0 = 0; t1 = 1;
          while (r1 != 0) begin
            q = r0 / r1;
            nr = r0 - q * r1;
            nt = fsub(t0, fmul(q % m, t1, m), m);
            r0 = r1; r1 = nr; t0 = t1; t1 = nt;
          end
          if (r0 == 1) begin
            lam = fmul(num, t0, m);
            x3 = fsub(fsub(fmul(lam, lam, m), x1, m), x2, m);
            y3 = fsub(fmul(lam, fsub(x1, x3, m), m), y1, m);
            s = '{sum_x: fe_t'(x3), sum_y: fe_t'(y3), at_infinity: 1'b0};
          end
        end
      end
      pending.push_back(s);
    endfunction

    function void check_sum(point_sum_t got);
      point_sum_t exp_s;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_s = pending.pop_front();
      if (got.sum_x !== exp_s.sum_x) begin
        $display("%0t: sum_x expected %0d actual %0d", $time, exp_s.sum_x, got.sum_x);
        errors++;
      end
      if (got.sum_y !== exp_s.sum_y) begin
        $display("%0t: sum_y expected %0d actual %0d", $time, exp_s.sum_y, got.sum_y);
        errors++;
      end
      if (got.at_infinity !== exp_s.at_infinity) begin
        $display("%0t: at_infinity expected %0b actual %0b", $time, exp_s.at_infinity,
                 got.at_infinity);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, out_at_infinity;
  fe_t in_first_x, in_first_y, in_second_x, in_second_y, out_sum_x, out_sum_y;
  logic cfg_valid, cfg_ready;
  cfg_idx_t cfg_index;
  fe_t cfg_data;

  point_sum_board board;
  int send_idle_pct = 0, stall_pct = 0;
  bit hold_off = 0;
  longint cycles = 0;

  ec_point_add_prime_field #(.FIELD_BITS(FB)) uut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL ec_point_add_prime_field");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_sum('{sum_x: out_sum_x, sum_y: out_sum_y, at_infinity: out_at_infinity});
  end

  // Receiver stall is chosen for the next cycle at each falling edge.
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  task automatic write_reg(cfg_idx_t idx, fe_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_CURVE_A) board.coeff_a = value;
    else board.modulus = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_points(fe_t x1, fe_t y1, fe_t x2, fe_t y2);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_first_x <= x1;
    in_first_y <= y1;
    in_second_x <= x2;
    in_second_y <= y2;
    do @(posedge clk); while (in_stall);
    board.note_points(x1, y1, x2, y2);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60 * (FB + 2)) @(posedge clk);
  endtask

  // Draws a coordinate, mostly reduced, sometimes the full width.
  function automatic fe_t coord();
    if (board.modulus >= 2 && $urandom_range(9) != 0)
      return fe_t'($urandom_range(board.modulus - 1));
    return fe_t'($urandom);
  endfunction

  // Points are mostly chosen to hit doubling, negation and generic adds.
  task automatic random_points(int n);
    fe_t x1, y1, x2, y2;
    fe_t m;
    repeat (n) begin
      m = board.modulus;
      x1 = coord();
      y1 = coord();
      case ($urandom_range(5))
        0: begin x2 = x1; y2 = y1; end
        1: begin
          x2 = x1;
          y2 = (m >= 2) ? fe_t'((m - (y1 % m)) % m) : coord();
        end
        2: begin x2 = ($urandom_range(1) != 0) ? fe_t'(x1 + m) : x1; y2 = y1; end
        default: begin x2 = coord(); y2 = coord(); end
      endcase
      send_points(x1, y1, x2, y2);
    end
  endtask

  initial begin
    fe_t primes[6] = '{16'd23, 16'd3, 16'd65521, 16'd251, 16'd7919, 16'd40009};
    board = new();
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = CFG_CURVE_A;
    cfg_data = '0;
    in_first_x = '0; in_first_y = '0; in_second_x = '0; in_second_y = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed points under the reset curve.
    send_points(16'd3, 16'd10, 16'd9, 16'd7);
    send_points(16'd3, 16'd10, 16'd3, 16'd10);
    send_points(16'd3, 16'd10, 16'd3, 16'd13);
    send_points(16'd5, 16'd0, 16'd5, 16'd0);
    send_points(16'd0, 16'd0, 16'd0, 16'd0);
    send_points(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_points(16'd26, 16'd33, 16'd3, 16'd10);
    send_points(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_points(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
    drain();
    write_reg(CFG_CURVE_A, 16'hFFFF);
    write_reg(CFG_MODULUS, 16'hFFF1);
    send_points(16'd1, 16'd2, 16'd1, 16'd2);
    send_points(16'hFFF0, 16'hFFF0, 16'd1, 16'd1);
    drain();
    write_reg(CFG_MODULUS, 16'hFFFF);
    send_points(16'd2, 16'd5, 16'd5, 16'd7);
    send_points(16'd3, 16'd1, 16'd6, 16'd9);
    send_points(16'd4, 16'd4, 16'd4, 16'd4);
    drain();
    write_reg(CFG_MODULUS, 16'd1);
    send_points(16'd1, 16'd2, 16'd3, 16'd4);
    drain();
    write_reg(CFG_MODULUS, 16'd0);
    send_points(16'd1, 16'd1, 16'd1, 16'd1);
    drain();
    write_reg(CFG_MODULUS, 16'd15);
    write_reg(CFG_CURVE_A, 16'd0);
    send_points(16'd1, 16'd1, 16'd4, 16'd2);
    send_points(16'd2, 16'd3, 16'd2, 16'd3);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 21 : 56) : 0;
      stall_pct = (ph % 4 == 2) ? 56 : ((ph % 4 == 3) ? 21 : 0);
      write_reg(CFG_MODULUS, primes[ph % 6]);
      write_reg(CFG_CURVE_A, (ph == 7) ? 16'hFFFE : fe_t'($urandom));
      if (ph == 4) begin
        fork
          begin
            hold_off = 1;
            repeat (3000) @(posedge clk);
            hold_off = 0;
          end
          random_points(4);
        join
      end
      random_points(145);
      drain();
    end
    stall_pct = 0;
    send_idle_pct = 0;
    drain();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASS ec_point_add_prime_field");
    else
      $display("FAIL ec_point_add_prime_field");
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/ecpa_pkg.sv
hdl/ecpa_mulmod.sv
hdl/ec_point_add_prime_field.sv
dv/ec_point_add_prime_field_test.sv
